// ----- rtl/core/hsv_to_rgb888_defines.svh -----
// ----------------------------------------------------------------------------
// hsv_to_rgb888 assertion macros
// Shared concurrent assertion forms used by the converter modules.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB888_DEFINES_SVH
`define HSV_TO_RGB888_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSVRGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb888 assertion failed");

// next-cycle implication
`define HSVRGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb888 assertion failed");

`endif

// ----- rtl/core/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Constants and the queued work word shared by the HSV to RGB888 converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int UNIT_FRAC_BITS = 12;
  localparam int HUE_FRAC_BITS  = 4;
  localparam int UNIT_ONE       = 1 << UNIT_FRAC_BITS;
  localparam int HUE_UNIT       = 1 << HUE_FRAC_BITS;
  localparam int SECTOR_SPAN    = 60 * HUE_UNIT;
  localparam int CIRCLE_SPAN    = 360 * HUE_UNIT;
  localparam int SECTORS        = 6;

  // biased hue (hue + 32768) plus this offset is congruent to hue mod circle
  localparam int HUE_OFFSET     = CIRCLE_SPAN - (32768 % CIRCLE_SPAN);

  // sector span = SUB_DIV << LOW_BITS
  localparam int LOW_BITS       = 6;
  localparam int SUB_DIV        = SECTOR_SPAN >> LOW_BITS;
  localparam int RECIP_SHIFT    = 16;
  localparam int SUB_RECIP      = 65535 / SUB_DIV;
  localparam int SEC_RECIP      = 43;   // floor(q*43/256) == q/6 for q < 72
  localparam int SEC_SHIFT      = 8;

  // 255 / SECTOR_SPAN == 17 / 64, so byte = (17 * n) >> (2*UNIT_FRAC_BITS + 6)
  localparam int SCALE_NUM      = 17;
  localparam int SCALE_SHIFT    = 2 * UNIT_FRAC_BITS + LOW_BITS;

  localparam int VAL_W          = UNIT_FRAC_BITS + 1;
  localparam int NUM_W          = 10;
  localparam int C2_W           = 2 * UNIT_FRAC_BITS + 1;
  localparam int N_W            = 34;
  localparam int SC_W           = N_W + 5;

  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = 2;

  typedef struct packed {
    logic [2:0]       sector;
    logic [NUM_W-1:0] num;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] val;
  } hsvrgb_word_t;

endpackage

// ----- rtl/core/hsv_to_rgb888.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb888
// HSV to 8-bit RGB converter, one pixel word per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries hue (signed, 1/16 degree),
//   saturation and brightness (unsigned, 4096 = 1.0). Output channel
//   out_valid/out_ready carries the red, green and blue bytes, one word out
//   for every word in, in order.
//   A word passes from acceptance to out_valid through one front register,
//   the queue write, and four back stages ending in the output register.
//   Throughput is one word per clock while out_ready stays high; every back
//   stage holds at least one multiplier.
//   A 4-word queue separates front and back; when out_ready is low the back
//   stages fill, then the queue and the front register, and only then does
//   in_ready drop.
//   Synchronous active-low reset empties every stage and the queue; no
//   output word is valid after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb888 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_hue,
  input  logic [15:0]        in_saturation,
  input  logic [15:0]        in_brightness,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);
  import hsvrgb_pkg::*;

  logic         wr_valid, wr_ready;
  logic         rd_valid, rd_ready;
  hsvrgb_word_t wr_word;
  hsvrgb_word_t rd_word;

  hsvrgb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .wr_valid      (wr_valid),
    .wr_ready      (wr_ready),
    .wr_word       (wr_word)
  );

  hsvrgb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_word  (wr_word),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_word  (rd_word)
  );

  hsvrgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_ready  (rd_ready),
    .rd_word   (rd_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// ----- rtl/core/hsvrgb_front.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_front
// Accepts words, wraps the hue, finds sector and secondary numerator,
// saturates S and V, and hands a work word to the queue.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb888_defines.svh"

module hsvrgb_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       in_hue,
  input  logic [15:0]              in_saturation,
  input  logic [15:0]              in_brightness,
  output logic                     wr_valid,
  input  logic                     wr_ready,
  output hsvrgb_pkg::hsvrgb_word_t wr_word
);
  import hsvrgb_pkg::*;

  logic                f1_v_r;
  logic [10:0]         a_r;
  logic [6:0]          q0_r;
  logic [LOW_BITS-1:0] low_r;
  logic [VAL_W-1:0]    sat_r;
  logic [VAL_W-1:0]    val_r;

  logic [15:0]         hue_b;
  logic [16:0]         x;
  logic [23:0]         rprod;
  logic [VAL_W-1:0]    sat_c;
  logic [VAL_W-1:0]    val_c;

  logic [10:0]         rem_raw;
  logic [3:0]          rem;
  logic [6:0]          q;
  logic [11:0]         sprod;
  logic [3:0]          k;
  logic [2:0]          sector;
  logic [NUM_W-1:0]    f;
  logic [NUM_W-1:0]    num;

  assign in_ready = !f1_v_r || wr_ready;

  always_comb begin
    hue_b = {~in_hue[15], in_hue[14:0]};
    x     = {1'b0, hue_b} + 17'(HUE_OFFSET);
    rprod = 24'(x[16:LOW_BITS]) * 24'(SUB_RECIP);
    sat_c = (in_saturation > 16'(UNIT_ONE)) ? VAL_W'(UNIT_ONE) : in_saturation[VAL_W-1:0];
    val_c = (in_brightness > 16'(UNIT_ONE)) ? VAL_W'(UNIT_ONE) : in_brightness[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (in_ready) begin
      f1_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_r   <= x[16:LOW_BITS];
      q0_r  <= rprod[RECIP_SHIFT+6:RECIP_SHIFT];
      low_r <= x[LOW_BITS-1:0];
      sat_r <= sat_c;
      val_r <= val_c;
    end
  end

  always_comb begin
    rem_raw = a_r - 11'(q0_r) * 11'(SUB_DIV);
    if (rem_raw >= 11'(SUB_DIV)) begin
      q   = q0_r + 7'd1;
      rem = 4'(rem_raw - 11'(SUB_DIV));
    end else begin
      q   = q0_r;
      rem = rem_raw[3:0];
    end
    sprod  = 12'(q) * 12'(SEC_RECIP);
    k      = sprod[SEC_SHIFT+3:SEC_SHIFT];
    sector = 3'(q - 7'(k) * 7'(SECTORS));
    f      = {rem, low_r};
    num    = sector[0] ? (NUM_W'(SECTOR_SPAN) - f) : f;
  end

  assign wr_valid       = f1_v_r;
  assign wr_word.sector = sector;
  assign wr_word.num    = num;
  assign wr_word.sat    = sat_r;
  assign wr_word.val    = val_r;

  `HSVRGB_ASSERT_IMP(a_sector_range, wr_valid, (wr_word.sector <= 3'd5) && (wr_word.num <= NUM_W'(SECTOR_SPAN)))
  `HSVRGB_ASSERT_NXT(a_front_hold, f1_v_r && !wr_ready, f1_v_r && $stable(a_r) && $stable(low_r))

endmodule

// ----- rtl/core/hsvrgb_fifo.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_fifo
// Short queue of work words between the front and back sections.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb888_defines.svh"

module hsvrgb_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_valid,
  output logic                     wr_ready,
  input  hsvrgb_pkg::hsvrgb_word_t wr_word,
  output logic                     rd_valid,
  input  logic                     rd_ready,
  output hsvrgb_pkg::hsvrgb_word_t rd_word
);
  import hsvrgb_pkg::*;

  hsvrgb_word_t      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;
  logic              pop;

  assign wr_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_word  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wp_r] <= wr_word;
    end
  end

  `HSVRGB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= (QPTR_W+1)'(QDEPTH))
  `HSVRGB_ASSERT_NXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// ----- rtl/core/hsvrgb_back.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_back
// Stalling pipeline: chroma, secondary and minimum terms, sector routing,
// scaling to bytes and the output register.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb888_defines.svh"

module hsvrgb_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_valid,
  output logic                     rd_ready,
  input  hsvrgb_pkg::hsvrgb_word_t rd_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue
);
  import hsvrgb_pkg::*;

  function automatic logic [7:0] to_byte(input logic [N_W-1:0] n);
    logic [SC_W-1:0] sc;
    logic [8:0]      q;
    sc = SC_W'(n) * SC_W'(SCALE_NUM);
    q  = sc[SCALE_SHIFT+8:SCALE_SHIFT];
    return (q > 9'd255) ? 8'hFF : q[7:0];
  endfunction

  logic             s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic             s1_rdy, s2_rdy, s3_rdy, o_rdy;

  logic [C2_W-1:0]  c2_r;
  logic [VAL_W-1:0] v1_r;
  logic [NUM_W-1:0] num1_r;
  logic [2:0]       sec1_r;

  logic [N_W-1:0]   xn_r;
  logic [C2_W-1:0]  m2_r;
  logic [VAL_W-1:0] v2_r;
  logic [2:0]       sec2_r;

  logic [N_W-1:0]   nr_r, ng_r, nb_r;
  logic [N_W-1:0]   nc, nx, nz;
  logic [N_W-1:0]   nr, ng, nb;

  logic [7:0]       red_r, green_r, blue_r;

  assign o_rdy    = !out_v_r || out_ready;
  assign s3_rdy   = !s3_v_r || o_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign rd_ready = s1_rdy;

  always_comb begin
    nz = N_W'(m2_r) * N_W'(SECTOR_SPAN);
    nx = xn_r + nz;
    nc = (N_W'(v2_r) * N_W'(SECTOR_SPAN)) << UNIT_FRAC_BITS;
    unique case (sec2_r)
      3'd0: begin nr = nc; ng = nx; nb = nz; end
      3'd1: begin nr = nx; ng = nc; nb = nz; end
      3'd2: begin nr = nz; ng = nc; nb = nx; end
      3'd3: begin nr = nz; ng = nx; nb = nc; end
      3'd4: begin nr = nx; ng = nz; nb = nc; end
      default: begin nr = nc; ng = nz; nb = nx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= rd_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (o_rdy) begin
        out_v_r <= s3_v_r;
      end
    end
    if (rd_valid && s1_rdy) begin
      c2_r   <= C2_W'(rd_word.val) * C2_W'(rd_word.sat);
      v1_r   <= rd_word.val;
      num1_r <= rd_word.num;
      sec1_r <= rd_word.sector;
    end
    if (s1_v_r && s2_rdy) begin
      xn_r   <= N_W'(c2_r) * N_W'(num1_r);
      m2_r   <= (C2_W'(v1_r) << UNIT_FRAC_BITS) - c2_r;
      v2_r   <= v1_r;
      sec2_r <= sec1_r;
    end
    if (s2_v_r && s3_rdy) begin
      nr_r <= nr;
      ng_r <= ng;
      nb_r <= nb;
    end
    if (s3_v_r && o_rdy) begin
      red_r   <= to_byte(nr_r);
      green_r <= to_byte(ng_r);
      blue_r  <= to_byte(nb_r);
    end
  end

  assign out_valid = out_v_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  `HSVRGB_ASSERT_NXT(a_s3_hold, s3_v_r && !o_rdy, s3_v_r && $stable(nr_r) && $stable(nb_r))

endmodule
